// ===== hw/rtl/tte_pkg.sv =====
// Shared constants, codes and helpers for the tap tempo estimator.
`default_nettype none

package tte_pkg;

  // History ring depth and derived widths
  localparam int HISTORY_DEPTH = 9;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int COUNT_W       = $clog2(HISTORY_DEPTH + 1);

  // Field widths
  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int TEMPO_W = 16;

  // 60000 ms per minute times 64 sub-steps per bpm
  localparam int unsigned MS_PER_MINUTE_X64 = 3840000;
  localparam int NUM_W = $clog2(MS_PER_MINUTE_X64 * (HISTORY_DEPTH - 1) + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMPO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMPO  = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] TIMEOUT_MS_RST = 16'd2500;
  localparam logic [CFG_W-1:0] MIN_TEMPO_RST  = 16'd640;
  localparam logic [CFG_W-1:0] MAX_TEMPO_RST  = 16'd63936;

  // Slot that lies 'back' entries behind 'slot' around the ring
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0]  slot,
                                                  input logic [COUNT_W-1:0] back);
    logic [SLOT_W+1:0] sum;
    sum = {2'b00, slot} + (SLOT_W + 2)'(HISTORY_DEPTH) - (SLOT_W + 2)'(back);
    if (sum >= (SLOT_W + 2)'(HISTORY_DEPTH)) begin
      sum = sum - (SLOT_W + 2)'(HISTORY_DEPTH);
    end
    return sum[SLOT_W-1:0];
  endfunction

  // Next ring slot with wrap
  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W:0] inc;
    inc = {1'b0, slot} + (SLOT_W + 1)'(1);
    if (inc == (SLOT_W + 1)'(HISTORY_DEPTH)) begin
      inc = '0;
    end
    return inc[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tte_if.sv =====
// Valid/ready channel interfaces for taps and tempo results.
`default_nettype none

interface tte_tap_if;
  import tte_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] tap_time;
  modport source (output valid, output tap_time, input ready);
  modport sink   (input valid, input tap_time, output ready);
endinterface

interface tte_tempo_if;
  import tte_pkg::*;
  logic               valid;
  logic               ready;
  logic [TEMPO_W-1:0] tempo;
  logic               has_tempo;
  modport source (output valid, output tempo, output has_tempo, input ready);
  modport sink   (input valid, input tempo, input has_tempo, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tte_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module tte_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [tte_pkg::NUM_W-1:0]  dividend,
  input  wire logic [tte_pkg::TIME_W-1:0] divisor,
  output logic                            busy,
  output logic                            done,
  output logic [tte_pkg::NUM_W-1:0]       quotient
);
  import tte_pkg::*;

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] den;
  logic [ITER_W-1:0] iter;
  logic [TIME_W:0]   trial;
  logic              fits;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem, quotient[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  // Control: count iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= ITER_W'(NUM_W);
      end else if (busy) begin
        iter <= iter - ITER_W'(1);
        if (iter == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= TIME_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[TIME_W-1:0];
      end
      quotient <= {quotient[NUM_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tap_tempo_estimator_unit.sv =====
// Tap tempo estimator top level: tap history ring, sequencer, clamp and output register.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------
//  taps     | in  | valid/ready   | tap_time[31:0] (ms)
//  result   | out | valid/ready   | tempo[15:0] (1/64 bpm), has_tempo
//  cfg      | in  | cfg_write     | cfg_index[1:0], cfg_data[15:0]
//
// A tap with a positive span passes from acceptance to the next ready through these steps:
// accept, history check, span, the restoring divider (25 quotient bits plus done),
// then the load of the output register, which makes the result valid. Taps without
// a positive span skip the divider.
// A held result stalls the sequencer at the end only if it is still unread.
// Reset (rst, synchronous) empties the history and restores register defaults.
`default_nettype none

module tap_tempo_estimator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [tte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tte_pkg::CFG_W-1:0]     cfg_data,
  tte_tap_if.sink                            taps,
  tte_tempo_if.source                        result
);
  import tte_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SPAN  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]          state;
  logic [2:0]          state_next;

  logic [CFG_W-1:0]    timeout_ms;
  logic [CFG_W-1:0]    min_tempo;
  logic [CFG_W-1:0]    max_tempo;

  logic [TIME_W-1:0]   hist_mem [HISTORY_DEPTH];
  logic [SLOT_W-1:0]   rd_addr;
  logic [TIME_W-1:0]   rd_data;

  logic [COUNT_W-1:0]  tap_count;
  logic [SLOT_W-1:0]   write_slot;
  logic [TIME_W-1:0]   now;

  logic                do_clear;
  logic [COUNT_W-1:0]  count_eff;
  logic [SLOT_W-1:0]   slot_eff;
  logic [COUNT_W-1:0]  count_new;
  logic [SLOT_W-1:0]   slot_new;
  logic signed [TIME_W:0] diff;

  logic                span_ok;
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [NUM_W-1:0]    div_num;
  logic [NUM_W-1:0]    quotient;
  logic [NUM_W-1:0]    q_low;
  logic [NUM_W-1:0]    q_clamped;

  logic [TEMPO_W-1:0]  res_tempo;
  logic                res_has;
  logic                out_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_MS_RST;
      min_tempo  <= MIN_TEMPO_RST;
      max_tempo  <= MAX_TEMPO_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TIMEOUT_MS: timeout_ms <= cfg_data;
        REG_MIN_TEMPO:  min_tempo  <= cfg_data;
        REG_MAX_TEMPO:  max_tempo  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Signed difference of the current tap against the history read
  assign diff = $signed({1'b0, now}) - $signed({1'b0, rd_data});

  // Drop history when the gap exceeds the timeout
  assign do_clear  = (tap_count != '0) &&
                     (diff > $signed({{(TIME_W + 1 - CFG_W){1'b0}}, timeout_ms}));
  assign count_eff = do_clear ? '0 : tap_count;
  assign slot_eff  = do_clear ? '0 : write_slot;
  assign slot_new  = slot_next(slot_eff);
  assign count_new = (count_eff < COUNT_W'(HISTORY_DEPTH)) ? count_eff + COUNT_W'(1)
                                                            : count_eff;

  // Tempo needs two taps and a positive span
  assign span_ok   = (tap_count >= COUNT_W'(2)) && !diff[TIME_W] && (diff != '0);
  assign div_start = (state == ST_SPAN) && span_ok;
  assign div_num   = NUM_W'(MS_PER_MINUTE_X64) * NUM_W'(tap_count - COUNT_W'(1));

  // Read address: newest tap on accept, oldest tap after the write
  always_comb begin
    if (state == ST_CHECK) begin
      rd_addr = slot_back(slot_new, count_new);
    end else begin
      rd_addr = slot_back(write_slot, COUNT_W'(1));
    end
  end

  // History memory with registered read
  always_ff @(posedge clk) begin
    rd_data <= hist_mem[rd_addr];
    if (state == ST_CHECK) begin
      hist_mem[slot_eff] <= now;
    end
  end

  tte_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (diff[TIME_W-1:0]),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // Clamp: lower bound first, upper bound second
  assign q_low     = (quotient < NUM_W'(min_tempo)) ? NUM_W'(min_tempo) : quotient;
  assign q_clamped = (q_low > NUM_W'(max_tempo)) ? NUM_W'(max_tempo) : q_low;

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (taps.valid) state_next = ST_CHECK;
      ST_CHECK: state_next = ST_SPAN;
      ST_SPAN:  state_next = span_ok ? ST_DIV : ST_FIN;
      ST_DIV:   if (div_done) state_next = ST_FIN;
      ST_FIN:   if (!out_valid || result.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Sequencer, ring pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tap_count  <= '0;
      write_slot <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CHECK) begin
        tap_count  <= count_new;
        write_slot <= slot_new;
      end
      if (state == ST_FIN && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && taps.valid) begin
      now <= taps.tap_time;
    end
    if (state == ST_SPAN && !span_ok) begin
      res_tempo <= '0;
      res_has   <= 1'b0;
    end else if (state == ST_DIV && div_done) begin
      res_tempo <= q_clamped[TEMPO_W-1:0];
      res_has   <= 1'b1;
    end
    if (state == ST_FIN && (!out_valid || result.ready)) begin
      result.tempo     <= res_tempo;
      result.has_tempo <= res_has;
    end
  end

  assign taps.ready   = (state == ST_IDLE);
  assign result.valid = out_valid;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tap_count <= COUNT_W'(HISTORY_DEPTH))
    else $error("tap count beyond history depth");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot < SLOT_W'(HISTORY_DEPTH))
    else $error("write slot outside ring");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIV)
    else $error("divider busy outside divide state");

  a_no_tempo_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.has_tempo) |-> result.tempo == '0)
    else $error("tempo nonzero without estimate");

endmodule

`default_nettype wire

// ===== tb/sv/tb_tap_tempo_estimator_unit.sv =====
// Self-checking testbench for the tap tempo estimator: directed taps, random tap streams.
module tb_tap_tempo_estimator_unit;
  import tte_pkg::*;

  localparam int unsigned DEPTH = HISTORY_DEPTH;
  localparam longint unsigned BEAT_MS_X64 = 64'd3840000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_PER_PHASE = 315;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [TEMPO_W-1:0] tempo;
    logic               has_tempo;
  } tempo_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;

  tte_tap_if   tap_ch ();
  tte_tempo_if res_ch ();

  tap_tempo_estimator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .taps      (tap_ch),
    .result    (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Tempo predictor state: tap ring, fill level, write slot and register copies
  logic [TIME_W-1:0] hist_ms [DEPTH];
  int unsigned       held_taps = 0;
  int unsigned       next_slot = 0;
  logic [CFG_W-1:0]  cfg_timeout_ms = TIMEOUT_MS_RST;
  logic [CFG_W-1:0]  cfg_min_tempo  = MIN_TEMPO_RST;
  logic [CFG_W-1:0]  cfg_max_tempo  = MAX_TEMPO_RST;

  logic [TIME_W-1:0] tap_pending [$];
  tempo_res_t        tempo_expected [$];
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                mismatch_count = 0;
  int                cycle_count = 0;

  // Append one request to the pending queue
  function automatic void queue_tap(input logic [TIME_W-1:0] t);
    tap_pending.insert(tap_pending.size(), t);
  endfunction

  // Append one predicted result to the expected queue
  function automatic void queue_expected(input tempo_res_t r);
    tempo_expected.insert(tempo_expected.size(), r);
  endfunction

  // Store one tap and work out the clamped tempo it yields
  function automatic tempo_res_t estimate_tempo(input logic [TIME_W-1:0] now);
    tempo_res_t      res;
    longint          gap;
    longint          span;
    longint unsigned quot;
    int unsigned     oldest_slot;
    res = '0;
    if (held_taps > 0) begin
      gap = longint'({32'd0, now})
          - longint'({32'd0, hist_ms[(next_slot + DEPTH - 1) % DEPTH]});
      if (gap > longint'(cfg_timeout_ms)) begin
        held_taps = 0;
        next_slot = 0;
      end
    end
    hist_ms[next_slot] = now;
    next_slot = (next_slot + 1) % DEPTH;
    if (held_taps < DEPTH) held_taps++;
    if (held_taps >= 2) begin
      oldest_slot = (next_slot + DEPTH - held_taps) % DEPTH;
      span = longint'({32'd0, now}) - longint'({32'd0, hist_ms[oldest_slot]});
      if (span > 0) begin
        quot = BEAT_MS_X64 * longint'(held_taps - 1) / longint'(span);
        if (quot < cfg_min_tempo) quot = cfg_min_tempo;
        if (quot > cfg_max_tempo) quot = cfg_max_tempo;
        res.tempo     = quot[TEMPO_W-1:0];
        res.has_tempo = 1'b1;
      end
    end
    return res;
  endfunction

  // Pick the next tap time: mostly steady tapping, some boundary gaps and noise
  function automatic logic [TIME_W-1:0] next_tap_time(input logic [TIME_W-1:0] prev);
    int unsigned pick;
    int unsigned step;
    pick = $urandom_range(99, 0);
    step = 0;
    if (pick < 50) begin
      step = $urandom_range(cfg_timeout_ms, 1);
    end else if (pick < 62) begin
      step = $urandom_range(60, 1);
    end else if (pick < 68) begin
      step = cfg_timeout_ms + $urandom_range(1, 0);
    end else if (pick < 74) begin
      step = 0;
    end else if (pick < 82) begin
      return prev - $urandom_range(3000, 1);
    end else if (pick < 90) begin
      step = cfg_timeout_ms + $urandom_range(20000, 2);
    end else if (pick < 95) begin
      return $urandom();
    end else begin
      step = $urandom_range(50000000, 100000);
    end
    return prev + step;
  endfunction

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_TIMEOUT_MS: cfg_timeout_ms = value;
      REG_MIN_TEMPO:  cfg_min_tempo  = value;
      REG_MAX_TEMPO:  cfg_max_tempo  = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] timeout_val,
                              input logic [CFG_W-1:0] min_val,
                              input logic [CFG_W-1:0] max_val);
    write_reg(REG_TIMEOUT_MS, timeout_val);
    write_reg(REG_MIN_TEMPO, min_val);
    write_reg(REG_MAX_TEMPO, max_val);
  endtask

  // Hold until every request is taken and every tempo has come back
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (tap_pending.size() != 0 || tap_ch.valid || tempo_expected.size() != 0);
  endtask

  // Tap driver: predict on acceptance, then offer the next request
  always @(posedge clk) begin
    if (rst) begin
      tap_ch.valid <= 1'b0;
    end else begin
      if (tap_ch.valid && tap_ch.ready) begin
        queue_expected(estimate_tempo(tap_ch.tap_time));
      end
      if (!tap_ch.valid || tap_ch.ready) begin
        if (tap_pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          tap_ch.valid    <= 1'b1;
          tap_ch.tap_time <= tap_pending.pop_front();
        end else begin
          tap_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Tempo monitor: check each accepted result, stall at random
  always @(posedge clk) begin
    tempo_res_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (tempo_expected.size() == 0) begin
          $error("unexpected result: tempo %0d, has_tempo %0b", res_ch.tempo, res_ch.has_tempo);
          mismatch_count++;
        end else begin
          want = tempo_expected.pop_front();
          if (res_ch.tempo !== want.tempo) begin
            $error("tempo: expected %0d, got %0d", want.tempo, res_ch.tempo);
            mismatch_count++;
          end
          if (res_ch.has_tempo !== want.has_tempo) begin
            $error("has_tempo: expected %0b, got %0b", want.has_tempo, res_ch.has_tempo);
            mismatch_count++;
          end
        end
      end
      res_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [TIME_W-1:0] tap_clock;
    tap_ch.valid    = 1'b0;
    tap_ch.tap_time = '0;
    res_ch.ready    = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed taps at the reset register values
    @(negedge clk);
    send_idle_pct = 29;
    recv_idle_pct = 88;
    // steady 120 bpm until the ring wraps
    for (int i = 0; i <= 10; i++) queue_tap(32'(i * 500));
    // gap past the timeout clears, then a zero span and a backward step
    queue_tap(32'd7501);
    queue_tap(32'd7501);
    queue_tap(32'd7000);
    // gap exactly at the timeout keeps history
    queue_tap(32'd9500);
    queue_tap(32'd9501);
    // 1 ms taps at the top of the range hit the upper clamp, then wrap to zero
    queue_tap(32'hFFFF_FFF0);
    queue_tap(32'hFFFF_FFF1);
    queue_tap(32'h0000_0000);
    queue_tap(32'd5000);
    queue_tap(32'd7400);
    queue_tap(32'd7401);

    // Random tap streams under several register settings
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: program_regs(16'd2500, 16'd640, 16'd63936);
        1: program_regs(16'd65535, 16'd3840, 16'd63936);
        2: program_regs(16'd1, 16'd63936, 16'd64);
        3: program_regs(16'd3000, 16'd64, 16'd12800);
        4: program_regs(16'd20000, 16'd6400, 16'd6400);
        default: program_regs(16'd65535, 16'd64, 16'd63936);
      endcase
      // unknown index must leave the registers alone
      if (ph == 2) write_reg(REG_UNUSED, 16'h00FF);
      @(negedge clk);
      case (ph / 2)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      tap_clock = $urandom();
      repeat (RANDOM_PER_PHASE) begin
        tap_clock = next_tap_time(tap_clock);
        queue_tap(tap_clock);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tte_pkg.sv
hw/rtl/tte_if.sv
hw/rtl/tte_divider.sv
hw/rtl/tap_tempo_estimator_unit.sv
tb/sv/tb_tap_tempo_estimator_unit.sv
